@@ hdl/lps_pkg.sv @@
// Shared types, constants and helper functions for the line pixel stepper.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package lps_pkg;

   localparam int COORD_BITS  = 12;
   localparam int OFFSET_BITS = 12;
   localparam int BPP_BITS    = 4;
   localparam int PITCH_BITS  = 16;
   localparam int ADDR_BITS   = 30;
   localparam int COLOUR_BITS = 8;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // coordinate plus offset, one carry bit
   localparam int SUM_BITS    = ((COORD_BITS > OFFSET_BITS) ? COORD_BITS : OFFSET_BITS) + 1;
   localparam int PROD_X_BITS = SUM_BITS + BPP_BITS;
   localparam int PROD_Y_BITS = SUM_BITS + PITCH_BITS;

   localparam logic CMD_START = 1'b0;
   localparam logic CMD_STEP  = 1'b1;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_X_OFFSET        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_Y_OFFSET        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BYTES_PER_PIXEL = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ROW_PITCH       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_COLOURFUL_MODE  = 3'd4;

   localparam logic [COLOUR_BITS-1:0] COLOUR_WHITE = 8'hFF;

   typedef struct packed {
      logic                  cmd;
      logic [COORD_BITS-1:0] x_start;
      logic [COORD_BITS-1:0] y_start;
      logic [COORD_BITS-1:0] x_end;
      logic [COORD_BITS-1:0] y_end;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0]   pixel_address;
      logic [COLOUR_BITS-1:0] blue;
      logic [COLOUR_BITS-1:0] green;
      logic [COLOUR_BITS-1:0] red;
      logic                   last_pixel;
   } rsp_type;

   typedef struct packed {
      logic [OFFSET_BITS-1:0] x_offset;
      logic [OFFSET_BITS-1:0] y_offset;
      logic [BPP_BITS-1:0]    bytes_per_pixel;
      logic [PITCH_BITS-1:0]  row_pitch;
      logic                   colourful_mode;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      x_offset:        '0,
      y_offset:        '0,
      bytes_per_pixel: 4'd4,
      row_pitch:       16'd4096,
      colourful_mode:  1'b0
   };

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  last;
   } pixel_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // v mod 255: fold the bytes twice, then map 255 onto 0
   function automatic logic [COLOUR_BITS-1:0] mod255(input logic [COORD_BITS-1:0] v);
      logic [15:0] w;
      logic [8:0]  s;
      logic [7:0]  t;
      w = 16'(v);
      s = 9'(w[15:8]) + 9'(w[7:0]);
      t = s[7:0] + 8'(s[8]);
      return (t == 8'hFF) ? 8'h00 : t;
   endfunction

endpackage

`default_nettype wire

@@ hdl/lps_front.sv @@
// Front end: accepts start/step beats and runs the Bresenham stepping state.
// Pushes one pixel coordinate beat into the queue per productive item. Uses lps_pkg.
`default_nettype none

module lps_front (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire lps_pkg::req_type         req_payload,
   input  wire lps_pkg::queue_status_type queue_status,
   output logic                          push,
   output lps_pkg::pixel_type            push_pixel
);
   import lps_pkg::*;

   typedef struct packed {
      logic                  active;
      logic [COORD_BITS-1:0] cur_x;
      logic [COORD_BITS-1:0] cur_y;
      logic [COORD_BITS-1:0] major_end;
      logic [COORD_BITS:0]   major_delta;
      logic [COORD_BITS:0]   minor_delta;
      logic signed [COORD_BITS+1:0] error_acc;
      logic                  steep;
      logic                  y_down;
   } bres_state_type;

   bres_state_type state_ff, state_in;

   logic                  fire, is_start, swap;
   logic [COORD_BITS-1:0] x0, y0, x1, y1, dx, dy;
   logic                  start_y_down, start_steep, start_last;
   logic signed [COORD_BITS+1:0] err_sum, err_next;
   logic signed [COORD_BITS+2:0] err_twice, major_ext;
   logic                  minor_move;
   logic [COORD_BITS-1:0] x_inc, y_stepped, nx, ny;
   logic                  step_last;

   assign req_ready = !queue_status.full;
   assign fire      = req_valid && req_ready;
   assign is_start  = (req_payload.cmd == CMD_START);

   // start: order endpoints so x rises, then classify
   always_comb begin
      swap         = req_payload.x_start > req_payload.x_end;
      x0           = swap ? req_payload.x_end   : req_payload.x_start;
      y0           = swap ? req_payload.y_end   : req_payload.y_start;
      x1           = swap ? req_payload.x_start : req_payload.x_end;
      y1           = swap ? req_payload.y_start : req_payload.y_end;
      dx           = x1 - x0;
      start_y_down = y1 < y0;
      dy           = start_y_down ? (y0 - y1) : (y1 - y0);
      start_steep  = dy > dx;
      start_last   = (x0 == x1) && (y0 == y1);
   end

   // step: advance the major axis, move the minor one on error overflow
   always_comb begin
      err_sum    = state_ff.error_acc + $signed({1'b0, state_ff.minor_delta});
      err_twice  = {err_sum, 1'b0};
      major_ext  = $signed({2'b00, state_ff.major_delta});
      minor_move = err_twice >= major_ext;
      err_next   = minor_move ? (err_sum - $signed({1'b0, state_ff.major_delta})) : err_sum;
      x_inc      = state_ff.cur_x + COORD_BITS'(1);
      y_stepped  = state_ff.y_down ? (state_ff.cur_y - COORD_BITS'(1))
                                   : (state_ff.cur_y + COORD_BITS'(1));
      if (state_ff.steep) begin
         nx        = minor_move ? x_inc : state_ff.cur_x;
         ny        = y_stepped;
         step_last = (ny == state_ff.major_end);
      end else begin
         nx        = x_inc;
         ny        = minor_move ? y_stepped : state_ff.cur_y;
         step_last = (nx == state_ff.major_end);
      end
   end

   always_comb begin
      state_in = state_ff;
      push     = fire && (is_start || state_ff.active);
      if (is_start) begin
         push_pixel = '{x: x0, y: y0, last: start_last};
      end else begin
         push_pixel = '{x: nx, y: ny, last: step_last};
      end
      if (fire && is_start) begin
         state_in.active      = !start_last;
         state_in.cur_x       = x0;
         state_in.cur_y       = y0;
         state_in.major_end   = start_steep ? y1 : x1;
         state_in.major_delta = start_steep ? {1'b0, dy} : {1'b0, dx};
         state_in.minor_delta = start_steep ? {1'b0, dx} : {1'b0, dy};
         state_in.error_acc   = '0;
         state_in.steep       = start_steep;
         state_in.y_down      = start_y_down;
      end else if (fire && state_ff.active) begin
         state_in.active    = !step_last;
         state_in.cur_x     = nx;
         state_in.cur_y     = ny;
         state_in.error_acc = err_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   a_last_ends_line: assert property (@(posedge clock) disable iff (reset)
      (push && push_pixel.last) |=> !state_ff.active)
      else $error("line still active after its final pixel");

   a_idle_step_silent: assert property (@(posedge clock) disable iff (reset)
      (fire && !is_start && !state_ff.active) |-> !push)
      else $error("step while idle produced a pixel");

   a_error_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff.active |-> (state_ff.error_acc <= $signed({1'b0, state_ff.major_delta})))
      else $error("error term above major delta");

endmodule

`default_nettype wire

@@ hdl/lps_queue.sv @@
// Short pixel queue between the stepping front end and the address back end.
// Small register file with head read; depends on lps_pkg.
`default_nettype none

module lps_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire lps_pkg::pixel_type        push_pixel,
   input  wire logic                      pop,
   output lps_pkg::pixel_type             head_pixel,
   output lps_pkg::queue_status_type      status
);
   import lps_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   pixel_type             entry_ff [DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;

   assign head_pixel   = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + CNT_BITS'(1);
         2'b01:   count_in = count_ff - CNT_BITS'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_pixel;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full)
      else $error("push into a full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty)
      else $error("pop from an empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == CNT_BITS'($past(count_ff) + CNT_BITS'(1))))
      else $error("queue count lost a push");

endmodule

`default_nettype wire

@@ hdl/lps_back.sv @@
// Back end: turns queued pixel coordinates into byte address and colour.
// Three stalling register stages ending in the response register; uses lps_pkg.
`default_nettype none

module lps_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire lps_pkg::cfg_type          cfg,
   input  wire lps_pkg::queue_status_type queue_status,
   input  wire lps_pkg::pixel_type        head_pixel,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_ready,
   output lps_pkg::rsp_type               rsp_payload
);
   import lps_pkg::*;

   typedef struct packed {
      logic [SUM_BITS-1:0]   x_sum;
      logic [SUM_BITS-1:0]   y_sum;
      logic [COORD_BITS-1:0] abs_diff;
      logic                  diff_neg;
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic                  last;
   } sum_stage_type;

   typedef struct packed {
      logic [PROD_X_BITS-1:0] prod_x;
      logic [PROD_Y_BITS-1:0] prod_y;
      logic [COLOUR_BITS-1:0] blue;
      logic [COLOUR_BITS-1:0] green;
      logic [COLOUR_BITS-1:0] red;
      logic                   last;
   } prod_stage_type;

   logic           s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   logic           s1_en, s2_en, s3_en;
   sum_stage_type  s1_ff, s1_in;
   prod_stage_type s2_ff, s2_in;
   rsp_type        rsp_ff, rsp_in;
   logic [COLOUR_BITS-1:0] diff_mod;

   // each stage loads when empty or when the stage after it moves
   assign s3_en = !rsp_valid_ff || rsp_ready;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign pop   = !queue_status.empty && s1_en;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      s1_in.x_sum    = SUM_BITS'(head_pixel.x) + SUM_BITS'(cfg.x_offset);
      s1_in.y_sum    = SUM_BITS'(head_pixel.y) + SUM_BITS'(cfg.y_offset);
      s1_in.diff_neg = head_pixel.y < head_pixel.x;
      s1_in.abs_diff = s1_in.diff_neg ? (head_pixel.x - head_pixel.y)
                                      : (head_pixel.y - head_pixel.x);
      s1_in.x        = head_pixel.x;
      s1_in.y        = head_pixel.y;
      s1_in.last     = head_pixel.last;
   end

   // truncating remainder keeps the sign of y - x: negate the magnitude's residue
   always_comb begin
      diff_mod     = mod255(s1_ff.abs_diff);
      s2_in.prod_x = PROD_X_BITS'(s1_ff.x_sum) * PROD_X_BITS'(cfg.bytes_per_pixel);
      s2_in.prod_y = PROD_Y_BITS'(s1_ff.y_sum) * PROD_Y_BITS'(cfg.row_pitch);
      s2_in.blue   = mod255(s1_ff.x);
      s2_in.green  = mod255(s1_ff.y);
      s2_in.red    = s1_ff.diff_neg ? (COLOUR_BITS'(0) - diff_mod) : diff_mod;
      s2_in.last   = s1_ff.last;
   end

   always_comb begin
      rsp_in.pixel_address = ADDR_BITS'(s2_ff.prod_x) + ADDR_BITS'(s2_ff.prod_y);
      rsp_in.blue          = cfg.colourful_mode ? s2_ff.blue  : COLOUR_WHITE;
      rsp_in.green         = cfg.colourful_mode ? s2_ff.green : COLOUR_WHITE;
      rsp_in.red           = cfg.colourful_mode ? s2_ff.red   : COLOUR_WHITE;
      rsp_in.last_pixel    = s2_ff.last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s1_en) begin
            s1_valid_ff <= !queue_status.empty;
         end
         if (s2_en) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (s3_en) begin
            rsp_valid_ff <= s2_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_ff <= s1_in;
      end
      if (s2_en) begin
         s2_ff <= s2_in;
      end
      if (s3_en) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/line_pixel_stepper.sv @@
// Line pixel stepper: Bresenham rasteriser, one pixel beat per start item and per step item of an active line.
// An accepted item's pixel is registered in the queue, then in the back-end sum, product and response stages.
// Throughput: one item per cycle while the queue is not full; the stepping state update (add, compare) sets it.
// A four-entry queue lets the front keep accepting while the response side stalls.
// Reset is synchronous, active high: clears line state, queue and stages, and loads
// register defaults (offsets 0, 4 bytes per pixel, pitch 4096, white colour).
`default_nettype none

module line_pixel_stepper #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire lps_pkg::req_type                     req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output lps_pkg::rsp_type                          rsp_payload,
   input  wire logic                                 csr_write_enable,
   input  wire logic [lps_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [lps_pkg::CSR_DATA_BITS-1:0]    csr_write_data
);
   import lps_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             push, pop;
   pixel_type        push_pixel, head_pixel;
   queue_status_type queue_status;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_X_OFFSET:        cfg_in.x_offset        = csr_write_data[OFFSET_BITS-1:0];
            CSR_Y_OFFSET:        cfg_in.y_offset        = csr_write_data[OFFSET_BITS-1:0];
            CSR_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = csr_write_data[BPP_BITS-1:0];
            CSR_ROW_PITCH:       cfg_in.row_pitch       = csr_write_data[PITCH_BITS-1:0];
            CSR_COLOURFUL_MODE:  cfg_in.colourful_mode  = csr_write_data[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lps_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_payload  (req_payload),
      .queue_status (queue_status),
      .push         (push),
      .push_pixel   (push_pixel)
   );

   lps_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_pixel (push_pixel),
      .pop        (pop),
      .head_pixel (head_pixel),
      .status     (queue_status)
   );

   lps_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .head_pixel   (head_pixel),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_payload  (rsp_payload)
   );

   a_start_queues_pixel: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_payload.cmd == CMD_START) |=> !queue_status.empty)
      else $error("start beat left no pixel in the queue");

   a_ready_when_room: assert property (@(posedge clock) disable iff (reset)
      !queue_status.full |-> req_ready)
      else $error("front stalled with queue room");

   a_empty_no_response: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid straight after reset");

endmodule

`default_nettype wire
